>>> design/ptt_pkg.sv
// Shared types and constants for the page table translation block.
package ptt_pkg;

	localparam int PAGE_BYTES    = 128;
	localparam int TABLE_ENTRIES = 32;
	localparam int PHYS_PAGES    = 32;

	localparam int VADDR_W = 32;
	localparam int OFF_W   = $clog2(PAGE_BYTES);
	localparam int VPAGE_W = 25;
	localparam int PPAGE_W = 8;
	localparam int IDX_W   = 5;
	localparam int PA_W    = 12;
	localparam int CFG_W   = 6;
	localparam int TBL_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_PAGES_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		OP_TRANSLATE = 2'd0,
		OP_WRITE     = 2'd1,
		OP_READ      = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK           = 2'd0,
		STATUS_NOT_FOUND    = 2'd1,
		STATUS_OUT_OF_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_READ,
		RES_NOT_FOUND,
		RES_HIT
	} res_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic      accept;
		logic      write;
		logic      rd_issue;
		logic      scan;
		logic      mark;
		logic      set_kind;
		res_kind_t kind;
		logic      push;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       idx_ok;
		logic       hit;
		logic       issue_done;
		logic       cmp_pending;
		logic       out_free;
	} dp_sts_t;

endpackage

>>> design/ptt_ifs.sv
// Request and response channel interfaces of the page table translation block.
interface ptt_req_if import ptt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [VADDR_W-1:0] virtual_address;
	logic               is_write;
	logic [IDX_W-1:0]   entry_index;
	logic [VPAGE_W-1:0] new_virtual_page;
	logic [PPAGE_W-1:0] new_physical_page;
	logic               new_valid;

	modport source (output valid, operation, virtual_address, is_write, entry_index,
		new_virtual_page, new_physical_page, new_valid, input ready);
	modport sink (input valid, operation, virtual_address, is_write, entry_index,
		new_virtual_page, new_physical_page, new_valid, output ready);
endinterface

interface ptt_rsp_if import ptt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [PA_W-1:0]    physical_address;
	logic [VPAGE_W-1:0] read_virtual_page;
	logic [PPAGE_W-1:0] read_physical_page;
	logic               read_valid;
	logic               read_used;
	logic               read_dirty;

	modport source (output valid, status, physical_address, read_virtual_page,
		read_physical_page, read_valid, read_used, read_dirty, input ready);
	modport sink (input valid, status, physical_address, read_virtual_page,
		read_physical_page, read_valid, read_used, read_dirty, output ready);
endinterface

>>> design/ptt_datapath.sv
// Page table storage, sequential search, request latch and response register.
module ptt_datapath import ptt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ptt_req_if.sink          req,
	ptt_rsp_if.source        rsp,
	input  logic [CFG_W-1:0] pages_in_use,
	input  ctl_cmd_t         cmd,
	output dp_sts_t          sts
);

	logic [1:0]         op_q;
	logic [VADDR_W-1:0] vaddr_q;
	logic               wr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VPAGE_W-1:0] nvp_q;
	logic [PPAGE_W-1:0] npp_q;
	logic               nvalid_q;
	logic [CNT_W-1:0]   limit_q;

	logic [CNT_W-1:0]   scan_q;
	logic               cmp_vld_s1;
	logic [TBL_W-1:0]   cmp_idx_s1;
	res_kind_t          kind_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [TABLE_ENTRIES-1:0] dirty_q;

	logic [VPAGE_W-1:0] vp_mem [TABLE_ENTRIES];
	logic [PPAGE_W-1:0] pp_mem [TABLE_ENTRIES];

	logic [VPAGE_W-1:0] rd_vp_q;
	logic [PPAGE_W-1:0] rd_pp_q;
	logic               rd_valid_q;
	logic               rd_used_q;
	logic               rd_dirty_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [PA_W-1:0]    out_pa_q;
	logic [VPAGE_W-1:0] out_vp_q;
	logic [PPAGE_W-1:0] out_pp_q;
	logic               out_valid_mark_q;
	logic               out_used_q;
	logic               out_dirty_q;

	logic [TBL_W-1:0]   tidx;
	logic [TBL_W-1:0]   raddr;
	logic               idx_ok;
	logic               issue_done;
	logic               issue;
	logic               hit;
	logic               rd_en;

	status_t            res_status;
	logic [PA_W-1:0]    res_pa;
	logic [VPAGE_W-1:0] res_vp;
	logic [PPAGE_W-1:0] res_pp;
	logic               res_valid;
	logic               res_used;
	logic               res_dirty;

	assign tidx       = idx_q[TBL_W-1:0];
	assign idx_ok     = ({1'b0, idx_q} < (IDX_W + 1)'(TABLE_ENTRIES));
	assign issue_done = (scan_q >= limit_q);
	assign issue      = cmd.scan && !issue_done;
	assign raddr      = cmd.scan ? scan_q[TBL_W-1:0] : tidx;
	assign rd_en      = issue || cmd.rd_issue;
	assign hit        = cmp_vld_s1 && valid_q[cmp_idx_s1]
		&& (rd_vp_q == vaddr_q[VADDR_W-1:OFF_W]);

	assign sts.op          = op_q;
	assign sts.idx_ok      = idx_ok;
	assign sts.hit         = hit;
	assign sts.issue_done  = issue_done;
	assign sts.cmp_pending = cmp_vld_s1;
	assign sts.out_free    = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= req.operation;
			vaddr_q  <= req.virtual_address;
			wr_q     <= req.is_write;
			idx_q    <= req.entry_index;
			nvp_q    <= req.new_virtual_page;
			npp_q    <= req.new_physical_page;
			nvalid_q <= req.new_valid;
			limit_q  <= (pages_in_use > CFG_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
				: CNT_W'(pages_in_use);
		end
		if (issue) begin
			cmp_idx_s1 <= scan_q[TBL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			kind_q     <= RES_ZERO;
		end else begin
			cmp_vld_s1 <= issue;
			if (cmd.accept) begin
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (cmd.set_kind) begin
				kind_q <= cmd.kind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			dirty_q <= '0;
		end else if (cmd.write && idx_ok) begin
			valid_q[tidx] <= nvalid_q;
			used_q[tidx]  <= 1'b0;
			dirty_q[tidx] <= 1'b0;
		end else if (cmd.mark) begin
			used_q[cmp_idx_s1] <= 1'b1;
			if (wr_q) begin
				dirty_q[cmp_idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && idx_ok) begin
			vp_mem[tidx] <= nvp_q;
			pp_mem[tidx] <= npp_q;
		end
		if (rd_en) begin
			rd_vp_q <= vp_mem[raddr];
			rd_pp_q <= pp_mem[raddr];
		end
		if (cmd.rd_issue) begin
			rd_valid_q <= valid_q[tidx];
			rd_used_q  <= used_q[tidx];
			rd_dirty_q <= dirty_q[tidx];
		end
	end

	always_comb begin
		res_status = STATUS_OK;
		res_pa     = '0;
		res_vp     = '0;
		res_pp     = '0;
		res_valid  = 1'b0;
		res_used   = 1'b0;
		res_dirty  = 1'b0;
		unique case (kind_q)
			RES_READ: begin
				res_vp    = rd_vp_q;
				res_pp    = rd_pp_q;
				res_valid = rd_valid_q;
				res_used  = rd_used_q;
				res_dirty = rd_dirty_q;
			end
			RES_NOT_FOUND: begin
				res_status = STATUS_NOT_FOUND;
			end
			RES_HIT: begin
				if ({1'b0, rd_pp_q} < (PPAGE_W + 1)'(PHYS_PAGES)) begin
					res_pa = PA_W'({rd_pp_q, vaddr_q[OFF_W-1:0]});
				end else begin
					res_status = STATUS_OUT_OF_RANGE;
				end
			end
			default: begin
				res_status = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q     <= res_status;
			out_pa_q         <= res_pa;
			out_vp_q         <= res_vp;
			out_pp_q         <= res_pp;
			out_valid_mark_q <= res_valid;
			out_used_q       <= res_used;
			out_dirty_q      <= res_dirty;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = out_status_q;
	assign rsp.physical_address   = out_pa_q;
	assign rsp.read_virtual_page  = out_vp_q;
	assign rsp.read_physical_page = out_pp_q;
	assign rsp.read_valid         = out_valid_mark_q;
	assign rsp.read_used          = out_used_q;
	assign rsp.read_dirty         = out_dirty_q;

endmodule

>>> design/ptt_ctrl.sv
// Control state machine sequencing requests through the page table datapath.
module ptt_ctrl import ptt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.kind  = RES_ZERO;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.set_kind = 1'b1;
				state_d      = S_RESP;
				unique case (sts.op)
					OP_TRANSLATE: begin
						state_d = S_SCAN;
					end
					OP_WRITE: begin
						cmd.write = 1'b1;
						cmd.kind  = RES_ZERO;
					end
					OP_READ: begin
						if (sts.idx_ok) begin
							cmd.rd_issue = 1'b1;
							cmd.kind     = RES_READ;
						end else begin
							cmd.kind = RES_NOT_FOUND;
						end
					end
					default: begin
						cmd.kind = RES_ZERO;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.mark     = 1'b1;
					cmd.set_kind = 1'b1;
					cmd.kind     = RES_HIT;
					state_d      = S_RESP;
				end else if (sts.issue_done && !sts.cmp_pending) begin
					cmd.set_kind = 1'b1;
					cmd.kind     = RES_NOT_FOUND;
					state_d      = S_RESP;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> design/page_table_translate.sv
// Top level of the page table translation block.
//
// Requests arrive on req (valid/ready): translate, write entry or read entry.
// Each request yields exactly one response on rsp (valid/ready), in order.
// The search-length register pages_in_use sits on the APB port at address 0
// and should be written only while no request is in flight.
// One request is handled at a time. Write and read entry pass through the
// EXEC and RESP states after acceptance. A translate searches the table one
// entry per cycle through the single read port of the entry memory, so it
// checks up to min(pages_in_use, 32) entries, ending early on a match.
// The response register frees the request side: the next request is taken
// while a response still waits; a further one waits until it drains.
// Reset clears the valid, used and dirty marks and pages_in_use; the page
// numbers stay unknown until written. No clearing pass is needed.
// A stalled response holds its payload until rsp.ready is seen.
module page_table_translate import ptt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ptt_req_if.sink               req,
	ptt_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [CFG_W-1:0] pages_in_use_q;
	logic             reg_sel;
	ctl_cmd_t         cmd;
	dp_sts_t          sts;
	logic             ctl_ready;

	assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_PAGES_IN_USE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DATA_W'(pages_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_in_use_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			pages_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	assign req.ready = ctl_ready;

	ptt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ctl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.pages_in_use (pages_in_use_q),
		.cmd          (cmd),
		.sts          (sts)
	);

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!rsp.valid || rsp.ready))
		else $error("response pushed over an untaken response");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second request accepted while one is in flight");

	a_addr_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != STATUS_OK)) |-> (rsp.physical_address == '0))
		else $error("nonzero address with error status");

	a_mark_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark |-> (sts.hit && sts.op == OP_TRANSLATE))
		else $error("marks set without a translate hit");

endmodule
